[design/sss_pkg.sv]
// ---------------------------------------------------------------------------
// sss_pkg: shared types and constants of the seven segment bitmap scroller
// Holds the command and status codes, the register indexes, the segment
// table and the sequencer state type.
// ---------------------------------------------------------------------------
package sss_pkg;

    localparam logic [2:0] CMD_DRAW  = 3'd0;
    localparam logic [2:0] CMD_UP    = 3'd1;
    localparam logic [2:0] CMD_DOWN  = 3'd2;
    localparam logic [2:0] CMD_LEFT  = 3'd3;
    localparam logic [2:0] CMD_RIGHT = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NODIGIT = 2'd1;
    localparam logic [1:0] ST_BADCMD  = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_SEG  = 2'd2;

    localparam logic [6:0] RESET_ROWS = 7'd9;
    localparam logic [6:0] RESET_COLS = 7'd5;
    localparam logic [6:0] RESET_SEG  = 7'd3;
    localparam int         MAX_DIGIT  = 9;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_ROWS  = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // Bit 6 is segment a, bit 0 is segment g.
    function automatic logic [6:0] seg_bits(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0: s = 7'b1111110;
            4'd1: s = 7'b0110000;
            4'd2: s = 7'b1101101;
            4'd3: s = 7'b1111001;
            4'd4: s = 7'b0110011;
            4'd5: s = 7'b1011011;
            4'd6: s = 7'b1011111;
            4'd7: s = 7'b1110000;
            4'd8: s = 7'b1111111;
            4'd9: s = 7'b1111011;
            default: s = 7'b0000000;
        endcase
        return s;
    endfunction

endpackage

[design/seven_segment_bitmap_scroller.sv]
// ---------------------------------------------------------------------------
// seven_segment_bitmap_scroller: one-bit pixel frame with digit draw,
// rotation and row readout
// A small sequencer walks the frame memory one row per cycle.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  command   in         i_start high, o_busy low  i_cmd, i_digit, i_shift_count
//  config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//  result    out        o_strobe, one cycle       o_status .. o_last
//
//  Draw and read walk the rows of the frame memory; up, down, left and right
//  first run a 32-step bit-serial modulo of the shift count and then walk the
//  rows, up and down twice; others go straight to the result. A new command
//  is taken at the edge that takes the last result word.
//  After reset all min(MAX_ROWS, 64) rows of the frame are cleared while o_busy
//  is high. The receiver cannot stall; each result is shown for one cycle.
module seven_segment_bitmap_scroller #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_digit,
    input  logic [31:0] i_shift_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [5:0]  o_row_index,
    output logic [63:0] o_row_bits,
    output logic        o_last
);
    import sss_pkg::*;

    localparam int DEPTH = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RLIM  = DEPTH;
    localparam int CLIM  = MAX_COLS;

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    t_state      r_state;
    logic [6:0]  r_rows_cfg, r_cols_cfg, r_seg_cfg;
    logic [2:0]  r_cmd;
    logic [3:0]  r_digit;
    logic [31:0] r_cnt;
    logic [6:0]  r_rem;
    logic [5:0]  r_bit;
    logic [6:0]  r_ptr;
    logic [6:0]  r_ptr_d;
    logic        r_rd_v;
    logic        r_init;

    logic [6:0] rows, cols;
    always_comb begin
        rows = r_rows_cfg;
        if (rows < 7'd1) rows = 7'd1;
        if (rows > 7'(RLIM)) rows = 7'(RLIM);
        cols = r_cols_cfg;
        if (cols < 7'd1) cols = 7'd1;
        if (cols > 7'(CLIM)) cols = 7'(CLIM);
    end

    logic [63:0] cmask;
    assign cmask = (cols >= 7'd64) ? '1 : ((64'd1 << cols[5:0]) - 64'd1);

    // Geometry of the bars, all values signed 10 bits.
    // The thickness is length / 3, taken as (length * 43) >> 7, which is
    // exact for every length below 128.
    logic signed [9:0] l, h, hc1, ncol;
    logic [12:0] seg_x43;
    assign seg_x43 = 13'(r_seg_cfg) * 13'd43;
    assign l    = 10'(r_seg_cfg);
    assign h    = 10'(seg_x43[12:7]);
    assign ncol = 10'(cols);
    assign hc1  = (l + h < ncol - h) ? l + h : ncol - h;

    function automatic logic [63:0] span(input logic signed [9:0] c0,
                                         input logic signed [9:0] c1,
                                         input logic [63:0] m);
        logic [63:0] v;
        v = '0;
        for (int j = 0; j < 64; j++)
            if ($signed(10'(j)) >= c0 && $signed(10'(j)) < c1) v[j] = 1'b1;
        return v & m;
    endfunction

    logic [63:0] draw_row;
    logic signed [9:0] rr;
    logic signed [9:0] y2, y3, y4, y5;
    logic [6:0] sg;
    always_comb begin
        rr = 10'(r_ptr_d);
        sg = seg_bits(r_digit);
        y2 = h + l;
        y3 = y2 + h;
        y4 = y3 + l;
        y5 = y4 + h;
        draw_row = '0;
        if (sg[6] && rr < h) draw_row |= span(h, hc1, cmask);
        if (sg[5] && rr >= h && rr < y2) draw_row |= span(ncol - h, ncol, cmask);
        if (sg[4] && rr >= y3 && rr < y4) draw_row |= span(ncol - h, ncol, cmask);
        if (sg[3] && rr >= y4 && rr < y5) draw_row |= span(h, hc1, cmask);
        if (sg[2] && rr >= y3 && rr < y4) draw_row |= span(10'sd0, h, cmask);
        if (sg[1] && rr >= h && rr < y2) draw_row |= span(10'sd0, h, cmask);
        if (sg[0] && rr >= y2 && rr < y3) draw_row |= span(h, hc1, cmask);
    end

    // Column rotation by r_rem within cols bits.
    logic [63:0] rot_row, src;
    logic [6:0]  k_l;
    always_comb begin
        src = r_rdata & cmask;
        k_l = (r_cmd == CMD_LEFT) ? r_rem : ((r_rem == 7'd0) ? 7'd0 : cols - r_rem);
        rot_row = ((src >> k_l[5:0]) | (src << (cols - k_l))) & cmask;
        if (k_l == 7'd0) rot_row = src;
    end

    // Row source for up/down: destination row r_ptr takes source row.
    logic [6:0] src_row;
    logic [7:0] sr;
    always_comb begin
        if (r_cmd == CMD_UP) sr = 8'(r_ptr) + 8'(r_rem);
        else sr = 8'(r_ptr) + 8'(rows) - 8'(r_rem);
        if (sr >= 8'(rows)) sr = sr - 8'(rows);
        src_row = sr[6:0];
    end

    logic        n_we;
    logic [AW-1:0] n_waddr, n_raddr;
    logic [63:0] n_wdata;
    logic        n_re;

    logic [63:0] r_tmp [DEPTH];
    logic [63:0] r_tmp_q;

    logic [6:0]  rem_next;
    logic [7:0]  rem_sh;
    logic [6:0]  modulus;
    assign modulus = (r_cmd == CMD_UP || r_cmd == CMD_DOWN) ? rows : cols;
    assign rem_sh  = {r_rem, r_cnt[31]};
    assign rem_next = (rem_sh >= 8'(modulus)) ? 7'(rem_sh - 8'(modulus)) : rem_sh[6:0];

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        if (n_re) r_rdata <= r_mem[n_raddr];
    end

    logic vert;
    assign vert = (r_cmd == CMD_UP || r_cmd == CMD_DOWN);

    always_comb begin
        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                if (r_init) begin
                    n_we = 1'b1; n_waddr = r_ptr[AW-1:0]; n_wdata = '0;
                end else begin
                    n_re = r_ptr < rows; n_raddr = r_ptr[AW-1:0];
                    n_we = r_rd_v; n_waddr = r_ptr_d[AW-1:0];
                    n_wdata = (r_rdata & ~cmask) | draw_row;
                end
            end
            S_ROWS: begin
                n_re = r_ptr < rows;
                n_raddr = vert ? src_row[AW-1:0] : r_ptr[AW-1:0];
                n_we = r_rd_v && !vert; n_waddr = r_ptr_d[AW-1:0];
                n_wdata = (r_rdata & ~cmask) | rot_row;
            end
            S_WRITE: begin
                n_re = r_ptr < rows; n_raddr = r_ptr[AW-1:0];
                n_we = r_rd_v; n_waddr = r_ptr_d[AW-1:0];
                n_wdata = (r_rdata & ~cmask) | r_tmp_q;
            end
            S_READ: begin
                n_re = r_ptr < rows; n_raddr = r_ptr[AW-1:0];
            end
            default: ;
        endcase
    end

    // Vertical shifts stage the moved rows in a scratch copy.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROWS && r_rd_v && vert) r_tmp[r_ptr_d[AW-1:0]] <= src;
        if (r_state == S_WRITE && n_re) r_tmp_q <= r_tmp[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_init <= 1'b1; r_ptr <= '0; r_rd_v <= 1'b0;
            r_rows_cfg <= RESET_ROWS; r_cols_cfg <= RESET_COLS; r_seg_cfg <= RESET_SEG;
            o_strobe <= 1'b0; o_last <= 1'b0;
            r_cmd <= CMD_READ;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROWS: r_rows_cfg <= i_cfg_data;
                    REG_COLS: r_cols_cfg <= i_cfg_data;
                    REG_SEG:  r_seg_cfg  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_ptr_d <= r_ptr;
            r_rd_v  <= n_re;
            case (r_state)
                S_IDLE: begin
                    o_strobe <= 1'b0;
                    if (i_start) begin
                        r_cmd <= i_cmd; r_digit <= i_digit; r_cnt <= i_shift_count;
                        r_ptr <= '0; r_rem <= '0; r_bit <= '0;
                        if (i_cmd == CMD_DRAW && i_digit <= 4'(MAX_DIGIT))
                            r_state <= S_CLEAR;
                        else if (i_cmd == CMD_READ) r_state <= S_READ;
                        else if (i_cmd inside {[CMD_UP:CMD_RIGHT]}) r_state <= S_MOD;
                        else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CLEAR: begin
                    o_strobe <= 1'b0;
                    if (r_init) begin
                        if (r_ptr == 7'(DEPTH - 1)) begin
                            r_init <= 1'b0; r_state <= S_IDLE;
                        end
                        r_ptr <= r_ptr + 7'd1;
                    end else begin
                        if (r_ptr < rows) r_ptr <= r_ptr + 7'd1;
                        if (!n_re && !r_rd_v && r_ptr >= rows) r_state <= S_DONE;
                    end
                end
                S_MOD: begin
                    o_strobe <= 1'b0;
                    r_rem <= rem_next; r_cnt <= {r_cnt[30:0], 1'b0};
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'd31) r_state <= S_ROWS;
                end
                S_ROWS: begin
                    o_strobe <= 1'b0;
                    if (r_ptr < rows) r_ptr <= r_ptr + 7'd1;
                    if (!n_re && !r_rd_v && r_ptr >= rows) begin
                        r_ptr <= '0;
                        r_state <= vert ? S_WRITE : S_DONE;
                    end
                end
                S_WRITE: begin
                    o_strobe <= 1'b0;
                    if (r_ptr < rows) r_ptr <= r_ptr + 7'd1;
                    if (!n_re && !r_rd_v && r_ptr >= rows) r_state <= S_DONE;
                end
                S_READ: begin
                    o_strobe <= r_rd_v;
                    if (r_ptr < rows) r_ptr <= r_ptr + 7'd1;
                    if (r_rd_v) begin
                        o_status <= ST_OK;
                        o_row_index <= r_ptr_d[5:0];
                        o_row_bits <= r_rdata & cmask;
                        o_last <= (r_ptr_d == rows - 7'd1);
                        if (r_ptr_d == rows - 7'd1) r_state <= S_IDLE;
                    end
                end
                S_DONE: begin
                    o_strobe <= 1'b1; o_row_index <= '0; o_row_bits <= '0; o_last <= 1'b1;
                    if (r_cmd == CMD_DRAW) begin
                        o_status <= (r_digit > 4'(MAX_DIGIT)) ? ST_NODIGIT : ST_OK;
                    end else if (r_cmd inside {[CMD_UP:CMD_RIGHT]}) begin
                        o_status <= ST_OK;
                    end else begin
                        o_status <= ST_BADCMD;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    o_strobe <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> o_busy) else $error("read ended early");
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last && o_strobe |=> !o_strobe || !o_busy || $past(r_state) == S_IDLE)
        else $error("result after last");
endmodule

[tb/seven_segment_bitmap_scroller_test.sv]
// ---------------------------------------------------------------------------
// seven_segment_bitmap_scroller_test: self-checking bench of the scroller
// Drives draw, shift, read and invalid commands under several frame
// settings and idle patterns, predicts every result word from a private
// copy of the pixel frame and checks each strobed word in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module seven_segment_bitmap_scroller_test;
    import sss_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  row_index;
        logic [63:0] row_bits;
        logic        last;
    } t_word;

    class frame_scoreboard;
        logic [63:0] frame [64];
        int rows_reg, cols_reg, seg_reg;
        t_word pending [$];
        int errors;

        function new();
            foreach (frame[i]) frame[i] = '0;
            rows_reg = RESET_ROWS;
            cols_reg = RESET_COLS;
            seg_reg = RESET_SEG;
            errors = 0;
        endfunction

        function void note_config(logic [1:0] idx, logic [6:0] val);
            if (idx == REG_ROWS) rows_reg = val;
            else if (idx == REG_COLS) cols_reg = val;
            else if (idx == REG_SEG) seg_reg = val;
        endfunction

        function logic [63:0] col_mask(int cols);
            return cols >= 64 ? '1 : ((64'd1 << cols) - 64'd1);
        endfunction

        function void paint(int r0, int r1, int c0, int c1, int rows, int cols);
            if (r0 < 0) r0 = 0;
            if (c0 < 0) c0 = 0;
            if (r1 > rows) r1 = rows;
            if (c1 > cols) c1 = cols;
            for (int r = r0; r < r1; r++)
                for (int c = c0; c < c1; c++) frame[r][c] = 1'b1;
        endfunction

        function void note_command(logic [2:0] cmd, logic [3:0] digit,
                                   logic [31:0] count);
            int rows, cols, l, h, hc1, k;
            logic [6:0] s;
            logic [63:0] m, v;
            logic [63:0] tmp [64];
            t_word w;
            rows = rows_reg < 1 ? 1 : (rows_reg > 64 ? 64 : rows_reg);
            cols = cols_reg < 1 ? 1 : (cols_reg > 64 ? 64 : cols_reg);
            m = col_mask(cols);
            w.status = ST_OK;
            w.row_index = '0;
            w.row_bits = '0;
            w.last = 1'b1;
            if (cmd == CMD_READ) begin
                for (int i = 0; i < rows; i++) begin
                    w.row_index = 6'(i);
                    w.row_bits = frame[i] & m;
                    w.last = (i == rows - 1);
                    pending.push_back(w);
                end
                return;
            end
            if (cmd == CMD_DRAW) begin
                if (digit > MAX_DIGIT) begin
                    w.status = ST_NODIGIT;
                end else begin
                    for (int i = 0; i < rows; i++) frame[i] &= ~m;
                    l = seg_reg;
                    h = l / 3;
                    hc1 = (l + h < cols - h) ? l + h : cols - h;
                    s = seg_bits(digit);
                    if (s[6]) paint(0, h, h, hc1, rows, cols);
                    if (s[5]) paint(h, h + l, cols - h, cols, rows, cols);
                    if (s[4]) paint(2*h + l, 2*h + 2*l, cols - h, cols, rows, cols);
                    if (s[3]) paint(2*h + 2*l, 3*h + 2*l, h, hc1, rows, cols);
                    if (s[2]) paint(2*h + l, 2*h + 2*l, 0, h, rows, cols);
                    if (s[1]) paint(h, h + l, 0, h, rows, cols);
                    if (s[0]) paint(h + l, 2*h + l, h, hc1, rows, cols);
                end
            end else if (cmd == CMD_UP || cmd == CMD_DOWN) begin
                k = count % rows;
                for (int i = 0; i < rows; i++)
                    tmp[cmd == CMD_UP ? (i - k + rows) % rows : (i + k) % rows]
                        = frame[i] & m;
                for (int i = 0; i < rows; i++) frame[i] = (frame[i] & ~m) | tmp[i];
            end else if (cmd == CMD_LEFT || cmd == CMD_RIGHT) begin
                k = count % cols;
                for (int i = 0; i < rows; i++) begin
                    v = '0;
                    for (int j = 0; j < cols; j++)
                        if (frame[i][j])
                            v[cmd == CMD_LEFT ? (j - k + cols) % cols : (j + k) % cols] = 1'b1;
                    frame[i] = (frame[i] & ~m) | v;
                end
            end else begin
                w.status = ST_BADCMD;
            end
            pending.push_back(w);
        endfunction

        function void check_word(t_word got);
            t_word exp_w;
            if (pending.size() == 0) begin
                $error("unexpected result word status=%0d row=%0d", got.status,
                       got.row_index);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.status !== exp_w.status) begin
                $error("status expected %0d actual %0d", exp_w.status, got.status);
                errors++;
            end
            if (got.row_index !== exp_w.row_index) begin
                $error("row_index expected %0d actual %0d", exp_w.row_index,
                       got.row_index);
                errors++;
            end
            if (got.row_bits !== exp_w.row_bits) begin
                $error("row_bits expected %h actual %h", exp_w.row_bits, got.row_bits);
                errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("last expected %0d actual %0d", exp_w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [2:0]  i_cmd = '0;
    logic [3:0]  i_digit = '0;
    logic [31:0] i_shift_count = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [5:0]  o_row_index;
    logic [63:0] o_row_bits;
    logic        o_last;

    frame_scoreboard board = new();
    int idle_pct;
    int phase_idle [4] = '{0, 52, 0, 22};

    seven_segment_bitmap_scroller uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_strobe) begin
            w.status = o_status;
            w.row_index = o_row_index;
            w.row_bits = o_row_bits;
            w.last = o_last;
            board.check_word(w);
        end
    end

    // The start request stays up after it is taken; the next call or drain
    // replaces or drops it at the same edge.
    task automatic send_command(logic [2:0] cmd, logic [3:0] digit, logic [31:0] count);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd <= cmd;
        i_digit <= digit;
        i_shift_count <= count;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_command(cmd, digit, count);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.note_config(idx, val);
    endtask

    task automatic set_frame(int rows, int cols, int seg);
        drain();
        write_reg(REG_ROWS, 7'(rows));
        write_reg(REG_COLS, 7'(cols));
        write_reg(REG_SEG, 7'(seg));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_command();
        int pick;
        logic [31:0] cnt;
        logic [3:0] dg;
        pick = $urandom_range(99);
        cnt = $urandom_range(1) ? $urandom_range(70) : $urandom;
        dg = 4'($urandom);
        if (pick < 30) begin
            if ($urandom_range(11) <= 10) dg = 4'($urandom_range(9));
            send_command(CMD_DRAW, dg, cnt);
        end else if (pick < 75) begin
            send_command(3'($urandom_range(CMD_RIGHT, CMD_UP)), dg, cnt);
        end else if (pick < 92) begin
            send_command(CMD_READ, dg, $urandom);
        end else begin
            send_command(3'($urandom_range(CMD_RSVD7, CMD_RSVD6)), dg, $urandom);
        end
    endtask

    initial begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        send_command(CMD_READ, '0, '0);
        for (int d = 0; d < 16; d++) begin
            send_command(CMD_DRAW, 4'(d), '0);
            if (d < 3) send_command(CMD_READ, '0, '0);
        end
        send_command(CMD_UP, '0, 32'hFFFF_FFFF);
        send_command(CMD_DOWN, '0, 32'd10);
        send_command(CMD_LEFT, '0, 32'hFFFF_FFFF);
        send_command(CMD_RIGHT, '0, 32'd7);
        send_command(CMD_RSVD6, '0, '0);
        send_command(CMD_RSVD7, 4'hF, '0);
        send_command(CMD_READ, 4'hF, 32'hFFFF_FFFF);
        set_frame(64, 64, 64);
        send_command(CMD_DRAW, 4'd8, '0);
        send_command(CMD_READ, '0, '0);
        set_frame(0, 0, 0);
        send_command(CMD_DRAW, 4'd8, '0);
        send_command(CMD_READ, '0, '0);
        set_frame(127, 127, 127);
        send_command(CMD_DRAW, 4'd0, '0);
        send_command(CMD_READ, '0, '0);
        for (int p = 0; p < 8; p++) begin
            idle_pct = phase_idle[p % 4];
            case (p % 4)
                0: set_frame(9, 5, 3);
                1: set_frame($urandom_range(64, 1), $urandom_range(64, 1),
                             $urandom_range(64));
                2: set_frame($urandom_range(16, 1), $urandom_range(64, 1),
                             $urandom_range(20));
                default: set_frame($urandom_range(127), $urandom_range(127),
                                   $urandom_range(127));
            endcase
            for (int n = 0; n < 45; n++) begin
                random_command();
                if (n == 20) drain();
            end
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
design/sss_pkg.sv
design/seven_segment_bitmap_scroller.sv
tb/seven_segment_bitmap_scroller_test.sv
